FILE: hdl/wpool_pkg.sv
// ----------------------------------------------------------------------------
// wpool_pkg
// Shared types and constants of the 2-D window pooling unit.
// ----------------------------------------------------------------------------
package wpool_pkg;

	// Default image geometry.
	localparam int DEF_HEIGHT   = 64;
	localparam int DEF_WIDTH    = 64;
	localparam int DEF_CHANNELS = 16;

	// Request types.
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_AVG  = 2'd1;
	localparam logic [1:0] REQ_MAX  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WIN_H    = 3'd0;
	localparam logic [2:0] CFG_WIN_W    = 3'd1;
	localparam logic [2:0] CFG_STR_R    = 3'd2;
	localparam logic [2:0] CFG_STR_C    = 3'd3;
	localparam logic [2:0] CFG_PAD_T    = 3'd4;
	localparam logic [2:0] CFG_PAD_L    = 3'd5;
	localparam logic [2:0] CFG_CLAMP_LO = 3'd6;
	localparam logic [2:0] CFG_CLAMP_HI = 3'd7;

	// Signed coordinate wide enough for window bounds of any legal geometry.
	typedef logic signed [11:0] crd_t;

	typedef struct packed {
		logic [3:0]         win_h;
		logic [3:0]         win_w;
		logic [3:0]         str_r;
		logic [3:0]         str_c;
		logic [2:0]         pad_t;
		logic [2:0]         pad_l;
		logic signed [15:0] clamp_lo;
		logic signed [15:0] clamp_hi;
	} cfg_t;

	// One classified word between front and back. For a load, rs and cs hold
	// the row and column of the sample.
	typedef struct packed {
		logic [1:0]  op;
		logic        empty;
		crd_t        rs;
		crd_t        re;
		crd_t        cs;
		crd_t        ce;
		logic [3:0]  ch;
		logic [15:0] sample;
	} qent_t;

endpackage

FILE: hdl/wpool_front.sv
// ----------------------------------------------------------------------------
// wpool_front
// Accepts input words, drops the ones without effect and turns queries into
// clipped window bounds.
// ----------------------------------------------------------------------------
module wpool_front import wpool_pkg::*; #(
	parameter int HEIGHT   = DEF_HEIGHT,
	parameter int WIDTH    = DEF_WIDTH,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [5:0]  pos_row,
	input  logic [5:0]  pos_col,
	input  logic [3:0]  chan,
	input  logic [15:0] sample,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        q_push,
	output qent_t       q_data
);

	localparam crd_t H_C = crd_t'(HEIGHT);
	localparam crd_t W_C = crd_t'(WIDTH);
	localparam logic [8:0] C_C = 9'(CHANNELS);

	crd_t r0, c0, hs, he, ws, we, lim_r, lim_c;
	logic ch_ok, load_ok, keep;

	// Window origin, clipped start and end offsets.
	always_comb begin
		r0 = crd_t'({2'b00, 10'(pos_row * cfg.str_r)}) - crd_t'({9'd0, cfg.pad_t});
		c0 = crd_t'({2'b00, 10'(pos_col * cfg.str_c)}) - crd_t'({9'd0, cfg.pad_l});
		hs = (r0 < 0) ? -r0 : '0;
		ws = (c0 < 0) ? -c0 : '0;
		lim_r = H_C - r0;
		lim_c = W_C - c0;
		he = crd_t'({8'd0, cfg.win_h});
		if (lim_r < he) he = lim_r;
		we = crd_t'({8'd0, cfg.win_w});
		if (lim_c < we) we = lim_c;
	end

	// Classification of the word.
	always_comb begin
		ch_ok   = {5'd0, chan} < C_C;
		load_ok = (crd_t'({6'd0, pos_row}) < H_C) && (crd_t'({6'd0, pos_col}) < W_C) && ch_ok;
		q_data.op     = req_type;
		q_data.ch     = chan;
		q_data.sample = sample;
		q_data.empty  = (hs >= he) || (ws >= we);
		q_data.rs     = r0 + hs;
		q_data.re     = r0 + he;
		q_data.cs     = c0 + ws;
		q_data.ce     = c0 + we;
		unique case (req_type)
			REQ_LOAD: begin
				keep      = load_ok;
				q_data.rs = crd_t'({6'd0, pos_row});
				q_data.cs = crd_t'({6'd0, pos_col});
			end
			REQ_AVG, REQ_MAX: keep = ch_ok;
			default: keep = 1'b0;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: hdl/wpool_queue.sv
// ----------------------------------------------------------------------------
// wpool_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
module wpool_queue import wpool_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output qent_t head,
	output logic  full,
	output logic  empty
);

	qent_t      ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end

	assign head  = ent_q[rd_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;

endmodule

FILE: hdl/wpool_back.sv
// ----------------------------------------------------------------------------
// wpool_back
// Holds the image, scans query windows, divides averages, clamps and drives
// the result register.
// ----------------------------------------------------------------------------
module wpool_back import wpool_pkg::*; #(
	parameter int HEIGHT   = DEF_HEIGHT,
	parameter int WIDTH    = DEF_WIDTH,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  qent_t              head,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pooled_value,
	output logic               status
);

	localparam int DEPTH = HEIGHT * WIDTH * CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [4:0] DIV_LAST = 5'd23;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data_s1;
	logic        rd_v_s1;

	logic [2:0]         state_q;
	logic [1:0]         op_q;
	logic               empty_q;
	crd_t               r_q, c_q, re_q, cs_q, ce_q;
	logic [3:0]         ch_q;
	logic signed [23:0] acc_q;
	logic [7:0]         cnt_q;
	logic [23:0]        quo_q;
	logic [8:0]         rem_q;
	logic               neg_q;
	logic [4:0]         div_q;
	logic               out_valid_q;
	logic signed [15:0] out_val_q;
	logic               out_st_q;

	logic [AW-1:0]      addr;
	logic               mem_we;
	logic signed [23:0] smp, val, lo, hi;
	logic [8:0]         rem_sh;
	logic               avg_empty, take;

	function automatic logic [AW-1:0] mem_addr(input crd_t r, input crd_t c, input logic [3:0] ch);
		mem_addr = AW'((int'(r) * WIDTH + int'(c)) * CHANNELS + int'(ch));
	endfunction

	// Memory port control: loads write from idle, scans read.
	always_comb begin
		q_pop  = (state_q == ST_IDLE) && !q_empty;
		mem_we = q_pop && (head.op == REQ_LOAD);
		addr   = (state_q == ST_IDLE) ? mem_addr(head.rs, head.cs, head.ch)
		                              : mem_addr(r_q, c_q, ch_q);
	end

	// Image memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= head.sample;
		rd_data_s1 <= mem[addr];
	end

	// Final value, clamp and status.
	always_comb begin
		smp    = {{8{rd_data_s1[15]}}, rd_data_s1};
		rem_sh = {rem_q[7:0], quo_q[23]};
		lo     = {{8{cfg.clamp_lo[15]}}, cfg.clamp_lo};
		hi     = {{8{cfg.clamp_hi[15]}}, cfg.clamp_hi};
		val    = (op_q == REQ_AVG) ? (neg_q ? -$signed(quo_q) : $signed(quo_q)) : acc_q;
		if (val < lo) val = lo;
		if (val > hi) val = hi;
		avg_empty = empty_q && (op_q == REQ_AVG);
		take      = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= state_q == ST_SCAN;
			if (out_valid_q && !out_stall && !take) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && head.op != REQ_LOAD) begin
						state_q <= head.empty ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (c_q == ce_q - 1 && r_q == re_q - 1) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= (op_q == REQ_AVG) ? ST_PREP : ST_DONE;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_q == DIV_LAST) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop) begin
			op_q    <= head.op;
			empty_q <= head.empty;
			r_q     <= head.rs;
			c_q     <= head.cs;
			re_q    <= head.re;
			cs_q    <= head.cs;
			ce_q    <= head.ce;
			ch_q    <= head.ch;
			acc_q   <= (head.op == REQ_AVG) ? 24'sd0 : -24'sd32768;
			cnt_q   <= '0;
		end
		// Window walk, row by row.
		if (state_q == ST_SCAN) begin
			if (c_q == ce_q - 1) begin
				c_q <= cs_q;
				r_q <= r_q + crd_t'(1);
			end else begin
				c_q <= c_q + crd_t'(1);
			end
		end
		// Accumulate the sample read in the previous cycle.
		if (rd_v_s1) begin
			cnt_q <= cnt_q + 8'd1;
			if (op_q == REQ_AVG) acc_q <= acc_q + smp;
			else if (smp > acc_q) acc_q <= smp;
		end
		// Restoring division of the magnitude, one bit a cycle.
		if (state_q == ST_PREP) begin
			neg_q <= acc_q < 0;
			quo_q <= (acc_q < 0) ? 24'(-acc_q) : 24'(acc_q);
			rem_q <= '0;
			div_q <= '0;
		end
		if (state_q == ST_DIV) begin
			div_q <= div_q + 5'd1;
			if (rem_sh >= {1'b0, cnt_q}) begin
				rem_q <= rem_sh - {1'b0, cnt_q};
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
		if (take) begin
			out_val_q <= avg_empty ? 16'sd0 : val[15:0];
			out_st_q  <= avg_empty;
		end
	end

	assign out_valid    = out_valid_q;
	assign pooled_value = out_val_q;
	assign status       = out_st_q;

endmodule

FILE: hdl/window_pooling_2d_unit.sv
// ----------------------------------------------------------------------------
// window_pooling_2d_unit
// Average and max pooling over one stored HWC image of Q8.8 samples.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  input   | in  | in_valid / in_stall   | req_type pos_row pos_col chan sample
//  result  | out | out_valid / out_stall | pooled_value status
//  config  | in  | cfg_we                | cfg_index cfg_data
//
// A load is written to the image from idle; a query makes one memory read
// per window sample, and an average query then runs a one-bit-a-cycle
// divider.
// Reset clears control state and loads the register defaults; the image
// is not cleared. A stalled result is held while the front keeps filling
// its two-entry queue.
// ----------------------------------------------------------------------------
module window_pooling_2d_unit import wpool_pkg::*; #(
	parameter int HEIGHT   = DEF_HEIGHT,
	parameter int WIDTH    = DEF_WIDTH,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [5:0]         pos_row,
	input  logic [5:0]         pos_col,
	input  logic [3:0]         chan,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pooled_value,
	output logic               status
);

	cfg_t  cfg_q;
	qent_t push_data, head;
	logic  q_push, q_pop, q_full, q_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_h    <= 4'd2;
			cfg_q.win_w    <= 4'd2;
			cfg_q.str_r    <= 4'd2;
			cfg_q.str_c    <= 4'd2;
			cfg_q.pad_t    <= 3'd0;
			cfg_q.pad_l    <= 3'd0;
			cfg_q.clamp_lo <= -16'sd32768;
			cfg_q.clamp_hi <= 16'sd32767;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIN_H:    cfg_q.win_h    <= cfg_data[3:0];
				CFG_WIN_W:    cfg_q.win_w    <= cfg_data[3:0];
				CFG_STR_R:    cfg_q.str_r    <= cfg_data[3:0];
				CFG_STR_C:    cfg_q.str_c    <= cfg_data[3:0];
				CFG_PAD_T:    cfg_q.pad_t    <= cfg_data[2:0];
				CFG_PAD_L:    cfg_q.pad_l    <= cfg_data[2:0];
				CFG_CLAMP_LO: cfg_q.clamp_lo <= cfg_data;
				CFG_CLAMP_HI: cfg_q.clamp_hi <= cfg_data;
				default: ;
			endcase
		end
	end

	wpool_front #(.HEIGHT(HEIGHT), .WIDTH(WIDTH), .CHANNELS(CHANNELS)) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.pos_row  (pos_row),
		.pos_col  (pos_col),
		.chan     (chan),
		.sample   (sample),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (push_data)
	);

	wpool_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	wpool_back #(.HEIGHT(HEIGHT), .WIDTH(WIDTH), .CHANNELS(CHANNELS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pooled_value (pooled_value),
		.status       (status)
	);

`ifndef SYNTHESIS
	// An empty-window error always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> pooled_value == 16'sd0)
		else $error("error result with nonzero value");

	// The back only takes words that are present in the queue.
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// A full queue stalls the input side.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> in_stall && !q_push)
		else $error("push into a full queue");
`endif

endmodule
